// ===== design/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace block.
// Used by the channel interfaces, the window cell, the emitter and the top level.
`default_nettype none

package sfr_pkg;

    localparam int MAX_PAT    = 8;
    localparam int MAX_REPL   = 8;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_BYTES = 2'd3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef t_byte [MAX_PAT-1:0] t_win;
    typedef t_byte [MAX_REPL-1:0] t_rep;
    typedef logic [LEN_W-1:0] t_len;

    // A group of results produced by one accepted item.
    typedef struct packed {
        t_win bytes;
        t_len cnt;
        logic last;
        logic blank;
    } t_burst;

endpackage

`default_nettype wire

// ===== design/sfr_in_if.sv =====
// Input channel of the find-and-replace block: one line byte per transfer.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_in_if import sfr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  line_end;

    modport source (output valid, output data_byte, output line_end, input ready);
    modport sink (input valid, input data_byte, input line_end, output ready);
endinterface

`default_nettype wire

// ===== design/sfr_out_if.sv =====
// Output channel of the find-and-replace block: one result byte per transfer.
// Depends on sfr_pkg.
`default_nettype none

interface sfr_out_if import sfr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  byte_valid;
    logic  end_of_line;

    modport source (output valid, output out_byte, output byte_valid, output end_of_line,
                    input ready);
    modport sink (input valid, input out_byte, input byte_valid, input end_of_line,
                  output ready);
endinterface

`default_nettype wire

// ===== design/sfr_cell.sv =====
// One cell of the pending-byte window: holds a byte, takes the new byte or
// its right neighbor's byte, and compares against its pattern byte. Uses sfr_pkg.
`default_nettype none

module sfr_cell import sfr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_load,
    input  wire logic  i_wr_sel,
    input  wire logic  i_shift,
    input  wire t_byte i_new,
    input  wire t_byte i_right,
    input  wire t_byte i_pat,
    output t_byte      o_cur,
    output logic       o_eq
);

    t_byte r_byte;
    t_byte n_byte;

    // Window content as it stands once the incoming byte is placed.
    assign o_cur  = i_wr_sel ? i_new : r_byte;
    assign o_eq   = (o_cur == i_pat);
    assign n_byte = i_shift ? i_right : o_cur;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= n_byte;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfr_emit.sv =====
// Result serializer: a shift chain of up to eight bytes drained one per cycle, while the
// output is not stalled, into the output register. Depends on sfr_pkg and sfr_out_if.
`default_nettype none

module sfr_emit import sfr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_burst i_burst,
    output logic        o_ready,
    sfr_out_if.source   o_out
);

    t_win  r_q;
    t_len  r_left;
    logic  r_end;
    logic  r_blank;
    logic  r_ov;
    t_byte r_ob;
    logic  r_obv;
    logic  r_oend;
    logic  pop;

    assign pop     = (r_left != '0) && (!r_ov || o_out.ready);
    // A new group may load while the final byte of the current one moves out.
    assign o_ready = (r_left == '0) || ((r_left == t_len'(1)) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_load) begin
                r_left <= i_burst.cnt;
            end else if (pop) begin
                r_left <= r_left - t_len'(1);
            end
            if (pop) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q     <= i_burst.bytes;
            r_end   <= i_burst.last;
            r_blank <= i_burst.blank;
        end else if (pop) begin
            r_q <= t_win'({t_byte'(0), r_q[MAX_PAT-1:1]});
        end
        if (pop) begin
            r_ob   <= r_blank ? t_byte'(0) : r_q[0];
            r_obv  <= !r_blank;
            r_oend <= r_end && (r_left == t_len'(1));
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_ob;
    assign o_out.byte_valid  = r_obv;
    assign o_out.end_of_line = r_oend;

`ifndef ASSERT_OFF
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= t_len'(MAX_PAT))
        else $error("emit: pending result count exceeds the chain depth");

    a_blank_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_obv) |-> r_oend)
        else $error("emit: empty result without end of line");

    a_end_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_end && (r_left == t_len'(1))) |=> (r_ov && r_oend))
        else $error("emit: final result of a line lost its end flag");
`endif

endmodule

`default_nettype wire

// ===== design/stream_find_replace_unit.sv =====
// Stream find-and-replace: a row of window cells holds pending bytes.
// The results of an item enter the result shift chain and then the output register.
// Throughput: one byte per cycle while the output accepts; an item producing n results
// holds input until the result shift chain has drained them one byte at a time.
// Reset (synchronous, active low) clears configuration, window count and output valid.
// No clearing pass is needed after reset.
`default_nettype none

module stream_find_replace_unit import sfr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sfr_in_if.sink                     i_in,
    sfr_out_if.source                  o_out
);

    t_len   r_plen;
    t_win   r_pat;
    t_len   r_rlen;
    t_rep   r_repl;
    t_len   r_cnt;
    t_len   n_cnt;
    t_len   plen_eff;
    t_len   rlen_eff;
    t_len   cnt_eff;
    t_len   cnt_inc;
    logic   accept;
    logic   emit_ready;
    logic   full;
    logic   match;
    logic   shift;
    t_win   w_cur;
    logic [MAX_PAT-1:0] eq;
    logic [MAX_PAT-1:0] use_mask;
    t_burst burst;

    assign accept     = i_in.valid && emit_ready;
    assign i_in.ready = emit_ready;

    assign plen_eff = (r_plen > t_len'(MAX_PAT)) ? t_len'(MAX_PAT) : r_plen;
    assign rlen_eff = (r_rlen > t_len'(MAX_REPL)) ? t_len'(MAX_REPL) : r_rlen;
    assign cnt_eff  = (r_cnt >= plen_eff) ? t_len'(0) : r_cnt;
    assign cnt_inc  = cnt_eff + t_len'(1);
    assign full     = (cnt_inc == plen_eff);
    assign match    = &(eq | ~use_mask);

    for (genvar g = 0; g < MAX_PAT; g++) begin : g_cell
        t_byte right;
        if (g == MAX_PAT - 1) begin : g_tail
            assign right = t_byte'(0);
        end else begin : g_mid
            assign right = w_cur[g+1];
        end
        assign use_mask[g] = (t_len'(g) < plen_eff);

        sfr_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (accept),
            .i_wr_sel (cnt_eff[IDX_W-1:0] == IDX_W'(g)),
            .i_shift  (shift),
            .i_new    (i_in.data_byte),
            .i_right  (right),
            .i_pat    (r_pat[g]),
            .o_cur    (w_cur[g]),
            .o_eq     (eq[g])
        );
    end

    always_comb begin
        burst.bytes = w_cur;
        burst.cnt   = '0;
        burst.last  = i_in.line_end;
        burst.blank = 1'b0;
        n_cnt       = cnt_inc;
        shift       = 1'b0;
        if (plen_eff == '0) begin
            burst.cnt = t_len'(1);
            n_cnt     = '0;
        end else if (full && match) begin
            burst.bytes = r_repl;
            burst.cnt   = rlen_eff;
            n_cnt       = '0;
        end else if (i_in.line_end) begin
            // Flush every pending byte, the oldest first.
            burst.cnt = cnt_inc;
            n_cnt     = '0;
        end else if (full) begin
            burst.cnt = t_len'(1);
            shift     = 1'b1;
            n_cnt     = plen_eff - t_len'(1);
        end
        // A line that ends on a deleted match still reports its end.
        if (i_in.line_end && (burst.cnt == '0)) begin
            burst.blank = 1'b1;
            burst.cnt   = t_len'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_pat  <= '0;
            r_rlen <= '0;
            r_repl <= '0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PAT_LEN: begin
                        r_plen <= i_cfg_data[LEN_W-1:0];
                        r_cnt  <= '0;
                    end
                    REG_PAT_BYTES: begin
                        r_pat <= t_win'(i_cfg_data);
                    end
                    REG_REP_LEN: begin
                        r_rlen <= i_cfg_data[LEN_W-1:0];
                    end
                    REG_REP_BYTES: begin
                        r_repl <= t_rep'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    sfr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_burst (burst),
        .o_ready (emit_ready),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) || (r_cnt < plen_eff))
        else $error("top: pending count not below the pattern length");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.line_end && !i_cfg_we) |=> (r_cnt == '0))
        else $error("top: window not empty after the end of a line");

    a_pass_keeps_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (plen_eff == '0) && !i_cfg_we) |=> (r_cnt == '0))
        else $error("top: pass-through transfer left bytes pending");
`endif

endmodule

`default_nettype wire

// ===== sim/stream_find_replace_unit_tb.sv =====
// Self-checking testbench for stream_find_replace_unit: directed lines, then random lines.
// Expected bytes come from a behavioral find-and-replace predictor kept inside this file.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and the unit itself.
`timescale 1ns / 1ps

module stream_find_replace_unit_tb;
    import sfr_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_byte out_byte;
        logic  byte_valid;
        logic  end_of_line;
    } t_line_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfr_in_if  in_ch();
    sfr_out_if out_ch();

    stream_find_replace_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor copy of the configuration and the pending window.
    t_len cfg_pat_len;
    t_win cfg_pat_bytes;
    t_len cfg_rep_len;
    t_rep cfg_rep_bytes;
    t_win win_bytes;
    int   win_count;

    t_line_out replaced_q[$];
    int        fail_count;
    int        cycle_count;
    int        idle_pct;
    int        stall_pct;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int pat_len_eff();
        return (cfg_pat_len > MAX_PAT) ? MAX_PAT : int'(cfg_pat_len);
    endfunction

    // Computes the output bytes caused by one input byte and queues them.
    function automatic void replace_step(input t_byte b, input logic last);
        t_line_out res[$];
        int        plen;
        int        rlen;
        logic      hit;
        plen = pat_len_eff();
        rlen = (cfg_rep_len > MAX_REPL) ? MAX_REPL : int'(cfg_rep_len);
        if (plen == 0) begin
            win_count = 0;
            res.push_back('{b, 1'b1, last});
        end else begin
            if (win_count >= plen)
                win_count = 0;
            win_bytes[win_count] = b;
            win_count++;
            if (win_count == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (win_bytes[i] != cfg_pat_bytes[i])
                        hit = 1'b0;
                if (hit) begin
                    for (int i = 0; i < rlen; i++)
                        res.push_back('{cfg_rep_bytes[i], 1'b1, 1'b0});
                    win_count = 0;
                end else begin
                    res.push_back('{win_bytes[0], 1'b1, 1'b0});
                    for (int i = 1; i < win_count; i++)
                        win_bytes[i-1] = win_bytes[i];
                    win_count--;
                end
            end
            if (last) begin
                for (int i = 0; i < win_count; i++)
                    res.push_back('{win_bytes[i], 1'b1, 1'b0});
                win_count = 0;
                // A line that ends on a deleted match still closes with an empty marker.
                if (res.size() == 0)
                    res.push_back('{8'h00, 1'b0, 1'b1});
                else
                    res[res.size()-1].end_of_line = 1'b1;
            end
        end
        foreach (res[i])
            replaced_q.push_back(res[i]);
    endfunction

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PAT_LEN: begin
                cfg_pat_len = data[LEN_W-1:0];
                win_count   = 0;
            end
            REG_PAT_BYTES: cfg_pat_bytes = data;
            REG_REP_LEN:   cfg_rep_len = data[LEN_W-1:0];
            REG_REP_BYTES: cfg_rep_bytes = data;
            default: ;
        endcase
    endtask

    task automatic configure(input t_len plen, input logic [63:0] pbytes,
                             input t_len rlen, input logic [63:0] rbytes);
        write_reg(REG_PAT_LEN, CFG_DATA_W'(plen));
        write_reg(REG_PAT_BYTES, pbytes);
        write_reg(REG_REP_LEN, CFG_DATA_W'(rlen));
        write_reg(REG_REP_BYTES, rbytes);
        i_cfg_we <= 1'b0;
    endtask

    // Valid stays high after a transfer; the next call lowers it only for an idle gap.
    task automatic send_byte(input t_byte b, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.line_end  <= last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        replace_step(b, last);
    endtask

    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (replaced_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_pass_through();
        // Registers are still at reset: pattern length zero.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_quiet();
    endtask

    task automatic test_longer_replacement();
        configure(4'd2, 64'h6261, 4'd3, 64'h5A5958);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        wait_quiet();
    endtask

    task automatic test_delete_at_end();
        configure(4'd1, 64'h78, 4'd0, 64'h0);
        send_byte(8'h71, 1'b0);
        send_byte(8'h78, 1'b1);
        wait_quiet();
    endtask

    task automatic test_oversized_and_short();
        configure(4'hF, 64'h00FF_807F_0102_FE00, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < MAX_PAT; i++)
            send_byte(cfg_pat_bytes[i], i == MAX_PAT - 1);
        // A line shorter than the pattern comes out unchanged.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_quiet();
    endtask

    task automatic test_reconfig_discard();
        configure(4'd4, 64'h6463_6261, 4'd1, 64'h2D);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        wait_quiet();
        // Rewriting the pattern length drops the two pending bytes.
        configure(4'd4, 64'h6463_6261, 4'd1, 64'h2D);
        send_byte(8'h63, 1'b0);
        send_byte(8'h64, 1'b1);
        wait_quiet();
    endtask

    // Lines are mostly built from whole or partial copies of the pattern to reach matches.
    task automatic send_random_line(output int count);
        t_byte line_q[$];
        int    want;
        int    plen;
        int    pick;
        int    k;
        want = $urandom_range(1, 12);
        plen = pat_len_eff();
        while (line_q.size() < want) begin
            pick = $urandom_range(0, 9);
            k = 0;
            if (plen > 0 && pick < 4)
                k = plen;
            else if (plen > 0 && pick < 6)
                k = $urandom_range(1, plen);
            if (k > 0) begin
                for (int j = 0; j < k; j++)
                    line_q.push_back(cfg_pat_bytes[j]);
            end else if (plen > 0 && pick < 8) begin
                line_q.push_back(cfg_pat_bytes[$urandom_range(0, plen - 1)]);
            end else begin
                line_q.push_back(t_byte'($urandom_range(0, 255)));
            end
        end
        foreach (line_q[i])
            send_byte(line_q[i], i == line_q.size() - 1);
        count = line_q.size();
    endtask

    task automatic test_random_lines();
        int idle_set[4]  = '{0, 68, 0, 33};
        int stall_set[4] = '{0, 0, 68, 33};
        int sent;
        int n;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int c = 0; c < 2; c++) begin
                wait_quiet();
                configure(t_len'($urandom_range(0, 15)), {$urandom, $urandom},
                          t_len'($urandom_range(0, 15)), {$urandom, $urandom});
                sent = 0;
                while (sent < 6) begin
                    send_random_line(n);
                    sent += n;
                end
            end
        end
        wait_quiet();
    endtask

    // Output side: random back-pressure and the comparison of every transfer.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (replaced_q.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("Unexpected output: byte %02h valid %0b eol %0b",
                             out_ch.out_byte, out_ch.byte_valid, out_ch.end_of_line);
                fail_count++;
            end else begin
                if (out_ch.out_byte !== replaced_q[0].out_byte ||
                    out_ch.byte_valid !== replaced_q[0].byte_valid ||
                    out_ch.end_of_line !== replaced_q[0].end_of_line) begin
                    if (fail_count < MAX_REPORTS)
                        $display("Mismatch: expected byte %02h valid %0b eol %0b, got %02h %0b %0b",
                                 replaced_q[0].out_byte, replaced_q[0].byte_valid,
                                 replaced_q[0].end_of_line, out_ch.out_byte,
                                 out_ch.byte_valid, out_ch.end_of_line);
                    fail_count++;
                end
                void'(replaced_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        cycle_count     = 0;
        fail_count      = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        cfg_pat_len     = '0;
        cfg_pat_bytes   = '0;
        cfg_rep_len     = '0;
        cfg_rep_bytes   = '0;
        win_bytes       = '0;
        win_count       = 0;
        out_ch.ready    = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_PAT_LEN;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.line_end  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pass_through();
        test_longer_replacement();
        test_delete_at_end();
        test_oversized_and_short();
        test_reconfig_discard();
        test_random_lines();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== stream_find_replace_unit.f =====
design/sfr_pkg.sv
design/sfr_in_if.sv
design/sfr_out_if.sv
design/sfr_cell.sv
design/sfr_emit.sv
design/stream_find_replace_unit.sv
sim/stream_find_replace_unit_tb.sv
